@@ src/dpc_pkg.sv @@
// ----------------------------------------------------------------------------
// dpc_pkg: shared types and constants of the disparity to point cloud block
// Payload structs, register indexes and the job record passed front to back.
// ----------------------------------------------------------------------------
package dpc_pkg;

    localparam int FRAC_SHIFT = 8;
    localparam int SUBPIX     = 16;
    localparam int STEP_MAX   = 16;
    localparam logic [24:0] COUNT_MAX = 25'd16777216;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH   = 3'd0,
        REG_SAMPLING_STEP = 3'd1,
        REG_MIN_DISPARITY = 3'd2,
        REG_BASELINE_MM   = 3'd3,
        REG_FOCAL_PX      = 3'd4,
        REG_CENTER_X      = 3'd5,
        REG_CENTER_Y      = 3'd6,
        REG_COLOR_ENABLE  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] disparity;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic        end_of_frame;
    } t_pix_in;

    typedef struct packed {
        logic               point_valid;
        logic signed [31:0] x_mm;
        logic signed [31:0] y_mm;
        logic signed [31:0] z_mm;
        logic [23:0]        color_word;
        logic               frame_done;
        logic [24:0]        points_in_frame;
    } t_point_out;

    // Job handed from the front end to the arithmetic back end.
    typedef struct packed {
        logic               kept;
        logic [15:0]        disparity;
        logic signed [18:0] diff_x;   // col*16 - cx
        logic signed [18:0] diff_y;   // row*16 - cy
        logic [23:0]        color_word;
        logic               frame_done;
        logic [24:0]        points_in_frame;
    } t_job;

endpackage

@@ src/dpc_front.sv @@
// ----------------------------------------------------------------------------
// dpc_front: raster counters and pixel selection
// Tracks column, row and sampling phases, decides which pixels are kept.
// ----------------------------------------------------------------------------
module dpc_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  dpc_pkg::t_pix_in i_pix,
    input  logic [12:0]     i_frame_width,
    input  logic [4:0]      i_sampling_step,
    input  logic [15:0]     i_min_disparity,
    input  logic [15:0]     i_center_x,
    input  logic [15:0]     i_center_y,
    input  logic            i_color_enable,
    output logic            o_emit,
    output dpc_pkg::t_job   o_job
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [3:0]    r_cph, n_cph, r_rph, n_rph;
    logic [24:0]   r_cnt, n_cnt;
    logic [4:0]    step;
    logic [14:0]   width;
    logic          kept;
    logic [24:0]   cnt_inc;

    always_comb begin
        step = (i_sampling_step == 5'd0) ? 5'd1 :
               (i_sampling_step > 5'd16) ? 5'd16 : i_sampling_step;
        width = (i_frame_width == 13'd0) ? 15'd1 :
                ({2'b0, i_frame_width} > 15'(MAX_WIDTH)) ? 15'(MAX_WIDTH)
                                                       : {2'b0, i_frame_width};
        kept = (r_cph == 4'd0) && (r_rph == 4'd0) &&
               (i_pix.disparity >= i_min_disparity);
        cnt_inc = (kept && r_cnt < dpc_pkg::COUNT_MAX) ? r_cnt + 25'd1 : r_cnt;
        n_col = r_col; n_row = r_row; n_cph = r_cph; n_rph = r_rph; n_cnt = cnt_inc;
        if (i_pix.end_of_frame) begin
            n_col = '0; n_row = '0; n_cph = '0; n_rph = '0; n_cnt = '0;
        end else if (15'(r_col) + 15'd1 >= width) begin
            n_col = '0; n_cph = '0;
            if (32'(r_row) + 32'd1 >= 32'(MAX_HEIGHT)) begin
                n_row = '0; n_rph = '0;
            end else begin
                n_row = r_row + 1'b1;
                n_rph = ({1'b0, r_rph} + 5'd1 >= step) ? 4'd0 : r_rph + 4'd1;
            end
        end else begin
            n_col = r_col + 1'b1;
            n_cph = ({1'b0, r_cph} + 5'd1 >= step) ? 4'd0 : r_cph + 4'd1;
        end
        o_emit = kept || i_pix.end_of_frame;
        o_job.kept = kept;
        o_job.disparity = i_pix.disparity;
        o_job.diff_x = 19'($signed({1'b0, r_col, 4'b0})) - 19'($signed({3'b0, i_center_x}));
        o_job.diff_y = 19'($signed({1'b0, r_row, 4'b0})) - 19'($signed({3'b0, i_center_y}));
        o_job.color_word = (kept && i_color_enable) ?
                           {i_pix.blue, i_pix.green, i_pix.red} : 24'd0;
        o_job.frame_done = i_pix.end_of_frame;
        o_job.points_in_frame = i_pix.end_of_frame ? cnt_inc : 25'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0; r_row <= '0; r_cph <= '0; r_rph <= '0; r_cnt <= '0;
        end else if (i_take) begin
            r_col <= n_col; r_row <= n_row; r_cph <= n_cph;
            r_rph <= n_rph; r_cnt <= n_cnt;
        end
    end
endmodule

@@ src/dpc_fifo.sv @@
// ----------------------------------------------------------------------------
// dpc_fifo: short job queue between front and back
// Two-entry register queue so either side can stall on its own.
// ----------------------------------------------------------------------------
module dpc_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dpc_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output dpc_pkg::t_job o_job
);
    dpc_pkg::t_job r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

@@ src/dpc_back.sv @@
// ----------------------------------------------------------------------------
// dpc_back: reprojection arithmetic
// Forms numerators, runs one restoring divider three times per point.
// ----------------------------------------------------------------------------
module dpc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  dpc_pkg::t_job     i_job,
    output logic              o_pop,
    input  logic [15:0]       i_baseline_mm,
    input  logic [15:0]       i_focal_px,
    output logic              o_valid,
    input  logic              i_ready,
    output dpc_pkg::t_point_out o_pt
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_MUL1 = 6'b000010, S_MUL2 = 6'b000100,
        S_SETUP = 6'b001000, S_DIV = 6'b010000, S_OUT = 6'b100000
    } t_state;

    t_state        r_st;
    dpc_pkg::t_job r_job;
    logic [18:0]   r_mx, r_my;
    logic          r_nx, r_ny;
    logic [39:0]   r_mag [3];     // |num| before Q.8 shift
    logic [1:0]    r_sel;
    logic [47:0]   r_num;         // shifting numerator
    logic [16:0]   r_rem;
    logic [5:0]    r_bit;
    logic [47:0]   r_q;
    logic [31:0]   r_res [3];
    logic [34:0]   prod;
    logic [16:0]   trial;
    logic [31:0]   sat;
    logic          neg_sel;

    assign o_pop = (r_st == S_IDLE) && !i_empty;

    always_comb begin
        unique case (r_sel)
            2'd0:    prod = 35'(r_mx) * 35'(i_baseline_mm);
            2'd1:    prod = 35'(r_my) * 35'(i_baseline_mm);
            default: prod = 35'(i_baseline_mm) * 35'(i_focal_px);
        endcase
        trial = {r_rem[15:0], r_num[47]} - {1'b0, r_job.disparity};
        neg_sel = (r_sel == 2'd0) ? r_nx : (r_sel == 2'd1) ? r_ny : 1'b1;
        if (r_mag[r_sel] == 40'd0) sat = 32'd0;
        else if (neg_sel)
            sat = (r_q > 48'h80000000) ? 32'h80000000 : 32'(0 - r_q[31:0]);
        else
            sat = (r_q > 48'h7FFFFFFF) ? 32'h7FFFFFFF : r_q[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; o_valid <= 1'b0;
        end else begin
            unique case (r_st)
                S_IDLE: if (!i_empty) begin
                    r_job <= i_job;
                    r_mx <= i_job.diff_x[18] ? 19'(-i_job.diff_x) : i_job.diff_x;
                    r_my <= i_job.diff_y[18] ? 19'(-i_job.diff_y) : i_job.diff_y;
                    r_nx <= !i_job.diff_x[18] && i_job.diff_x != 19'd0;
                    r_ny <= !i_job.diff_y[18] && i_job.diff_y != 19'd0;
                    r_sel <= 2'd0;
                    r_st <= i_job.kept ? S_MUL1 : S_OUT;
                    if (!i_job.kept) begin
                        r_res[0] <= '0; r_res[1] <= '0; r_res[2] <= '0;
                    end
                end
                S_MUL1: begin
                    r_mag[r_sel] <= 40'(prod);
                    if (r_sel == 2'd2) begin r_sel <= 2'd0; r_st <= S_SETUP; end
                    else r_sel <= r_sel + 2'd1;
                end
                S_SETUP: begin
                    r_num <= {r_mag[r_sel], 8'b0};
                    r_rem <= '0; r_q <= '0; r_bit <= 6'd48; r_st <= S_DIV;
                end
                S_DIV: begin
                    if (r_bit == 6'd0) begin
                        r_res[r_sel] <= (r_job.disparity == 16'd0 && r_mag[r_sel] != 40'd0)
                            ? (neg_sel ? 32'h80000000 : 32'h7FFFFFFF) : sat;
                        if (r_sel == 2'd2) r_st <= S_OUT;
                        else begin r_sel <= r_sel + 2'd1; r_st <= S_SETUP; end
                    end else begin
                        if (!trial[16]) begin
                            r_rem <= trial; r_q <= {r_q[46:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[15:0], r_num[47]}; r_q <= {r_q[46:0], 1'b0};
                        end
                        r_num <= {r_num[46:0], 1'b0};
                        r_bit <= r_bit - 6'd1;
                    end
                end
                S_OUT: if (!o_valid || i_ready) begin
                    o_valid <= 1'b1;
                    o_pt.point_valid <= r_job.kept;
                    o_pt.x_mm <= r_res[0]; o_pt.y_mm <= r_res[1];
                    o_pt.z_mm <= r_job.kept ? r_res[2] : 32'd0;
                    o_pt.color_word <= r_job.color_word;
                    o_pt.frame_done <= r_job.frame_done;
                    o_pt.points_in_frame <= r_job.points_in_frame;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
            if (o_valid && i_ready && r_st != S_OUT) o_valid <= 1'b0;
        end
    end
endmodule

@@ src/disparity_to_point_cloud.sv @@
// ----------------------------------------------------------------------------
// disparity_to_point_cloud: stereo disparity reprojection to 3D points
// Raster disparity pixels in, saturated Q.8 millimetre points out.
// ----------------------------------------------------------------------------
// A pixel that is dropped and does not end a frame is taken and gives no item,
// as long as the queue has room; while the queue is full every pixel waits. A
// kept pixel or a frame end passes a two-entry queue to the arithmetic unit,
// which does three multiplies and three 48-bit restoring divisions on one
// shared divider, one point at a time; the divider sets the rate. A frame end
// without a point skips the arithmetic and goes straight to the output state.
module disparity_to_point_cloud #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  dpc_pkg::t_pix_in    i_pix,
    output logic                o_valid,
    input  logic                i_ready,
    output dpc_pkg::t_point_out o_pt,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    logic [12:0] r_width;
    logic [4:0]  r_step;
    logic [15:0] r_mind, r_base, r_focal, r_cx, r_cy;
    logic        r_cen;
    logic        emit, full, empty, pop, take;
    dpc_pkg::t_job job_f, job_b;

    assign o_cfg_ready = 1'b1;

    // config writes, masked to register width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 13'd640; r_step <= 5'd4; r_mind <= 16'd160;
            r_base <= 16'd120; r_focal <= 16'd8000; r_cx <= 16'd5120;
            r_cy <= 16'd3840; r_cen <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (dpc_pkg::t_reg_idx'(i_cfg_index))
                dpc_pkg::REG_FRAME_WIDTH:   r_width <= i_cfg_data[12:0];
                dpc_pkg::REG_SAMPLING_STEP: r_step  <= i_cfg_data[4:0];
                dpc_pkg::REG_MIN_DISPARITY: r_mind  <= i_cfg_data;
                dpc_pkg::REG_BASELINE_MM:   r_base  <= i_cfg_data;
                dpc_pkg::REG_FOCAL_PX:      r_focal <= i_cfg_data;
                dpc_pkg::REG_CENTER_X:      r_cx    <= i_cfg_data;
                dpc_pkg::REG_CENTER_Y:      r_cy    <= i_cfg_data;
                dpc_pkg::REG_COLOR_ENABLE:  r_cen   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // front stalls whenever the queue is full, job or not
    assign o_ready = !full;
    assign take    = i_valid && o_ready;

    dpc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk, .i_rst_n, .i_take(take), .i_pix,
        .i_frame_width(r_width), .i_sampling_step(r_step),
        .i_min_disparity(r_mind), .i_center_x(r_cx), .i_center_y(r_cy),
        .i_color_enable(r_cen), .o_emit(emit), .o_job(job_f)
    );

    dpc_fifo u_fifo (
        .i_clk, .i_rst_n, .i_push(take && emit), .i_job(job_f), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_job(job_b)
    );

    dpc_back u_back (
        .i_clk, .i_rst_n, .i_empty(empty), .i_job(job_b), .o_pop(pop),
        .i_baseline_mm(r_base), .i_focal_px(r_focal),
        .o_valid, .i_ready, .o_pt
    );

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty) else $error("queue popped while empty");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !o_ready) else $error("input accepted with queue full");
    a_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_pt.frame_done) |-> (o_pt.points_in_frame == 25'd0))
        else $error("count shown without frame end");
endmodule

@@ tb/disparity_to_point_cloud_tb.sv @@
// ----------------------------------------------------------------------------
// disparity_to_point_cloud_tb: self-checking bench for the point cloud block
// Drives raster disparity frames under several register settings and idling
// phases, predicts each point and frame-end item, and checks them in order.
// ----------------------------------------------------------------------------

// Holds the expected point items and the bench's own copy of block state.
class point_scoreboard;
    dpc_pkg::t_point_out pending_points[$];
    int errors;
    // registers
    logic [12:0] width_r;
    logic [4:0]  step_r;
    logic [15:0] min_disp, base_mm, focal, cx, cy;
    logic        colour_on;
    // raster state
    int unsigned col, row, col_ph, row_ph, kept;

    function new();
        errors = 0;
        width_r = 13'd640; step_r = 5'd4; min_disp = 16'd160; base_mm = 16'd120;
        focal = 16'd8000; cx = 16'd5120; cy = 16'd3840; colour_on = 1'b1;
        col = 0; row = 0; col_ph = 0; row_ph = 0; kept = 0;
    endfunction

    function void write_reg(dpc_pkg::t_reg_idx idx, logic [15:0] data);
        case (idx)
            dpc_pkg::REG_FRAME_WIDTH:   width_r = data[12:0];
            dpc_pkg::REG_SAMPLING_STEP: step_r = data[4:0];
            dpc_pkg::REG_MIN_DISPARITY: min_disp = data;
            dpc_pkg::REG_BASELINE_MM:   base_mm = data;
            dpc_pkg::REG_FOCAL_PX:      focal = data;
            dpc_pkg::REG_CENTER_X:      cx = data;
            dpc_pkg::REG_CENTER_Y:      cy = data;
            default:                    colour_on = data[0];
        endcase
    endfunction

    // Truncated, sign-applied quotient saturated to 32 bits.
    function logic [31:0] sat_div(bit neg, logic [63:0] mag, logic [15:0] den);
        logic [63:0] q;
        if (mag == 0) return 32'd0;
        q = (den == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : mag / den;
        if (neg) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return 32'(-q);
        end
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function logic [31:0] lateral_mm(int unsigned idx, logic [15:0] ctr, logic [15:0] d);
        longint diff;
        logic [63:0] mag;
        diff = longint'(idx) * dpc_pkg::SUBPIX - longint'(ctr);
        mag = (diff < 0) ? 64'(-diff) : 64'(diff);
        return sat_div(diff > 0, (mag * base_mm) << dpc_pkg::FRAC_SHIFT, d);
    endfunction

    function void note_pixel(dpc_pkg::t_pix_in p);
        dpc_pkg::t_point_out o;
        int unsigned stp, wd;
        bit keep;
        stp = (step_r == 0) ? 1 : (step_r > dpc_pkg::STEP_MAX) ? dpc_pkg::STEP_MAX : step_r;
        wd = (width_r == 0) ? 1 : (width_r > 4096) ? 4096 : width_r;
        keep = col_ph == 0 && row_ph == 0 && p.disparity >= min_disp;
        o = '0;
        if (keep) begin
            o.point_valid = 1'b1;
            o.x_mm = lateral_mm(col, cx, p.disparity);
            o.y_mm = lateral_mm(row, cy, p.disparity);
            o.z_mm = sat_div(1'b1, (64'(base_mm) * focal) << dpc_pkg::FRAC_SHIFT,
                             p.disparity);
            o.color_word = colour_on ? {p.blue, p.green, p.red} : 24'd0;
            if (kept < dpc_pkg::COUNT_MAX) kept++;
        end
        if (p.end_of_frame) begin
            o.frame_done = 1'b1;
            o.points_in_frame = 25'(kept);
            col = 0; row = 0; col_ph = 0; row_ph = 0; kept = 0;
            pending_points.push_back(o);
            return;
        end
        if (col + 1 >= wd) begin
            col = 0; col_ph = 0;
            if (row + 1 >= 4096) begin
                row = 0; row_ph = 0;
            end else begin
                row++;
                row_ph = (row_ph + 1 >= stp) ? 0 : row_ph + 1;
            end
        end else begin
            col++;
            col_ph = (col_ph + 1 >= stp) ? 0 : col_ph + 1;
        end
        if (keep) pending_points.push_back(o);
    endfunction

    function void check_point(dpc_pkg::t_point_out got);
        dpc_pkg::t_point_out want;
        if (pending_points.size() == 0) begin
            $error("unexpected item %h", got);
            errors++;
            return;
        end
        want = pending_points.pop_front();
        if (got.point_valid !== want.point_valid) begin
            $error("point_valid exp %0d got %0d", want.point_valid, got.point_valid); errors++;
        end
        if (got.x_mm !== want.x_mm) begin
            $error("x_mm exp %0d got %0d", want.x_mm, got.x_mm); errors++;
        end
        if (got.y_mm !== want.y_mm) begin
            $error("y_mm exp %0d got %0d", want.y_mm, got.y_mm); errors++;
        end
        if (got.z_mm !== want.z_mm) begin
            $error("z_mm exp %0d got %0d", want.z_mm, got.z_mm); errors++;
        end
        if (got.color_word !== want.color_word) begin
            $error("color_word exp %h got %h", want.color_word, got.color_word); errors++;
        end
        if (got.frame_done !== want.frame_done) begin
            $error("frame_done exp %0d got %0d", want.frame_done, got.frame_done); errors++;
        end
        if (got.points_in_frame !== want.points_in_frame) begin
            $error("points_in_frame exp %0d got %0d", want.points_in_frame,
                   got.points_in_frame); errors++;
        end
    endfunction
endclass

module disparity_to_point_cloud_tb;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid, o_ready;
    dpc_pkg::t_pix_in    i_pix;
    logic                o_valid, i_ready;
    dpc_pkg::t_point_out o_pt;
    logic                i_cfg_valid, o_cfg_ready;
    logic [2:0]          i_cfg_index;
    logic [15:0]         i_cfg_data;

    // idle percentages per side, changed between phases
    int unsigned send_idle_pct, recv_stall_pct;
    int unsigned stall_cycles;
    bit          run_done;
    point_scoreboard sb;

    disparity_to_point_cloud u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_pix(i_pix),
        .o_valid(o_valid), .i_ready(i_ready), .o_pt(o_pt),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Receiver: random back-pressure; checks every item taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) sb.check_point(o_pt);
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: cycles with no item accepted on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT && !run_done) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Valid is left up on return; the next pixel send drops it.
    task automatic write_reg(dpc_pkg::t_reg_idx idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // One pixel item; a random gap goes before it, never while valid is up.
    // Valid stays high on return so back-to-back items need no gap.
    task automatic send_pixel(logic [15:0] d, logic eof);
        dpc_pkg::t_pix_in p;
        i_cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        p.disparity = d;
        p.blue = 8'($urandom); p.green = 8'($urandom); p.red = 8'($urandom);
        p.end_of_frame = eof;
        i_valid <= 1'b1;
        i_pix   <= p;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_pixel(p);
    endtask

    // Mostly kept-looking disparities, some below threshold, some extremes.
    function automatic logic [15:0] pick_disp();
        int unsigned k;
        k = $urandom_range(9);
        if (k == 0) return 16'd0;
        if (k == 1) return 16'hFFFF;
        if (k < 4) return 16'($urandom_range(16'hFFFF));
        return 16'(sb.min_disp + $urandom_range(2000));
    endfunction

    // Small frame: width cols by rows lines, end marked on the last pixel.
    task automatic send_frame(int unsigned cols, int unsigned rows);
        for (int unsigned i = 0; i < cols * rows; i++)
            send_pixel(pick_disp(), i == cols * rows - 1);
    endtask

    // Let the block drain, then the arithmetic tail after the last item.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending_points.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic random_setting(bit extreme);
        write_reg(dpc_pkg::REG_FRAME_WIDTH, extreme ? 16'($urandom_range(1) ? 1 : 8191)
                                                    : 16'($urandom_range(2, 12)));
        write_reg(dpc_pkg::REG_SAMPLING_STEP, extreme ? 16'($urandom_range(1) ? 0 : 31)
                                                      : 16'($urandom_range(1, 4)));
        write_reg(dpc_pkg::REG_MIN_DISPARITY,
                  $urandom_range(1) ? 16'($urandom_range(0, 200))
                                    : 16'($urandom_range(16'hFFFF)));
        write_reg(dpc_pkg::REG_BASELINE_MM, 16'($urandom_range(16'hFFFF)));
        write_reg(dpc_pkg::REG_FOCAL_PX, ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom));
        write_reg(dpc_pkg::REG_CENTER_X, 16'($urandom));
        write_reg(dpc_pkg::REG_CENTER_Y, 16'($urandom));
        write_reg(dpc_pkg::REG_COLOR_ENABLE, 16'($urandom_range(1)));
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0; i_pix = '0; i_ready = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = dpc_pkg::REG_FRAME_WIDTH; i_cfg_data = '0;
        send_idle_pct = 0; recv_stall_pct = 0; stall_cycles = 0; run_done = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, then extremes of every register.
        send_pixel(16'd160, 1'b0);      // first pixel, kept at threshold
        send_pixel(16'hFFFF, 1'b0);     // dropped by phase
        send_pixel(16'd0, 1'b1);        // frame end, one point so far
        send_pixel(16'd0, 1'b1);        // frame end without a point
        drain();
        write_reg(dpc_pkg::REG_FRAME_WIDTH, 16'd0);      // acts as one column
        write_reg(dpc_pkg::REG_SAMPLING_STEP, 16'd0);    // acts as one
        write_reg(dpc_pkg::REG_MIN_DISPARITY, 16'd0);    // zero disparity can be kept
        write_reg(dpc_pkg::REG_BASELINE_MM, 16'hFFFF);
        write_reg(dpc_pkg::REG_FOCAL_PX, 16'd0);         // zero focal length
        write_reg(dpc_pkg::REG_CENTER_X, 16'hFFFF);
        write_reg(dpc_pkg::REG_CENTER_Y, 16'd0);
        write_reg(dpc_pkg::REG_COLOR_ENABLE, 16'd0);
        send_pixel(16'd0, 1'b0);        // zero disparity, saturates
        send_pixel(16'd1, 1'b0);
        send_pixel(16'hFFFF, 1'b1);
        drain();
        write_reg(dpc_pkg::REG_FRAME_WIDTH, 16'h1FFF);   // clipped to the maximum width
        write_reg(dpc_pkg::REG_SAMPLING_STEP, 16'd31);   // clipped to sixteen
        write_reg(dpc_pkg::REG_FOCAL_PX, 16'hFFFF);
        write_reg(dpc_pkg::REG_CENTER_X, 16'd0);
        write_reg(dpc_pkg::REG_CENTER_Y, 16'hFFFF);
        write_reg(dpc_pkg::REG_COLOR_ENABLE, 16'd1);
        write_reg(dpc_pkg::REG_MIN_DISPARITY, 16'hFFFF);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'hFFFE, 1'b0);
        send_pixel(16'd1, 1'b1);
        drain();
        write_reg(dpc_pkg::REG_BASELINE_MM, 16'd0);      // zero numerators
        write_reg(dpc_pkg::REG_MIN_DISPARITY, 16'd1);
        write_reg(dpc_pkg::REG_FRAME_WIDTH, 16'd2);
        write_reg(dpc_pkg::REG_SAMPLING_STEP, 16'd1);
        send_frame(2, 3);
        drain();

        // Random phases over varied settings and idling.
        for (int ph = 0; ph < 38; ph++) begin
            case (ph % 5)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                3: begin send_idle_pct = 31; recv_stall_pct = 31; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            random_setting(ph % 8 == 7);
            for (int f = 0; f < 3; f++)
                send_frame(sb.width_r == 0 ? 1 : (sb.width_r > 12 ? 5 : sb.width_r),
                           $urandom_range(1, 4));
            drain();
        end

        run_done = 1;
        if (sb.errors == 0 && sb.pending_points.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
